>>> design/dfd_pkg.sv
// shared types, constants and helpers of the dibit frame deframer
package dfd_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SYMBOL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_RUN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd2;

    // register reset values
    localparam logic [1:0]  SYNC_SYMBOL_RST = 2'd0;
    localparam logic [7:0]  SYNC_RUN_RST    = 8'd16;
    localparam logic [15:0] MAX_LEN_RST     = 16'd1500;

    // descrambler
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // header layout: two 16-bit words, last dibit lands at bit 30
    localparam logic [4:0] HDR_LAST_POS = 5'd30;
    // payload: byte completes when the dibit lands at bit 6
    localparam logic [2:0] BYTE_LAST_SH = 3'd6;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_HEADER    = 2'd1,
        KIND_KEEPALIVE = 2'd2,
        KIND_OVERSIZE  = 2'd3
    } t_kind;

    // configuration registers as seen by the parser
    typedef struct packed {
        logic [1:0]  sync_symbol;
        logic [7:0]  sync_run;
        logic [15:0] max_len;
    } t_cfg;

    // one Galois step, shift right and toggle on the output bit
    function automatic logic [15:0] lfsr_next(input logic [15:0] l);
        lfsr_next = (l >> 1) ^ (l[0] ? LFSR_TAPS : 16'h0000);
    endfunction

    function automatic logic [15:0] swap16(input logic [15:0] v);
        swap16 = {v[7:0], v[15:8]};
    endfunction

endpackage

>>> design/dfd_cfg_regs.sv
// configuration register file of the dibit frame deframer
module dfd_cfg_regs
    import dfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_symbol <= SYNC_SYMBOL_RST;
            r_cfg.sync_run    <= SYNC_RUN_RST;
            r_cfg.max_len     <= MAX_LEN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYNC_SYMBOL: r_cfg.sync_symbol <= i_cfg_data[1:0];
                CFG_SYNC_RUN:    r_cfg.sync_run    <= i_cfg_data[7:0];
                CFG_MAX_LEN:     r_cfg.max_len     <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

>>> design/dfd_parser.sv
// sync search, header gather, payload descrambler and result register
module dfd_parser
    import dfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_step,
    input  logic [1:0]  i_dibit,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [1:0]  o_event_kind,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_sequence_number,
    output logic [15:0] o_frame_length,
    output logic        o_last_byte
);

    typedef enum logic [1:0] {
        M_SEARCH  = 2'd0,
        M_HEADER  = 2'd1,
        M_PAYLOAD = 2'd2
    } t_mode;

    // parse state
    t_mode       r_mode,   n_mode;
    logic [18:0] r_pos,    n_pos;
    logic [7:0]  r_cnt,    n_cnt;
    logic [15:0] r_seq,    n_seq;
    logic [15:0] r_len,    n_len;
    logic [15:0] r_lfsr,   n_lfsr;
    logic [7:0]  r_gather, n_gather;

    // result register
    logic        r_out_valid;
    t_kind       r_kind;
    logic [7:0]  r_byte;
    logic [15:0] r_out_seq;
    logic [15:0] r_out_len;
    logic        r_last;

    // result of the current transaction
    logic        res_valid;
    t_kind       res_kind;
    logic [7:0]  res_byte;
    logic        res_last;

    // helpers
    logic [15:0] lfsr_a;
    logic [15:0] lfsr_b;
    logic        b0;
    logic        b1;
    logic [18:0] pos_inc;
    logic [7:0]  cnt_sat;
    logic [15:0] len_swapped;

    assign lfsr_a      = lfsr_next(r_lfsr);
    assign lfsr_b      = lfsr_next(lfsr_a);
    assign b0          = i_dibit[0] ^ r_lfsr[0];
    assign b1          = i_dibit[1] ^ lfsr_a[0];
    assign pos_inc     = r_pos + 19'd2;
    assign cnt_sat     = (r_cnt == 8'hFF) ? r_cnt : r_cnt + 8'd1;
    assign len_swapped = swap16({i_dibit, r_len[15:2]});

    // next state and result for one dibit
    always_comb begin
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_cnt     = r_cnt;
        n_seq     = r_seq;
        n_len     = r_len;
        n_lfsr    = r_lfsr;
        n_gather  = r_gather;
        res_valid = 1'b0;
        res_kind  = KIND_PAYLOAD;
        res_byte  = 8'h00;
        res_last  = 1'b0;
        case (r_mode)
            M_HEADER: begin
                // words fill lsb first, so shift in from the top
                if (!r_pos[4]) begin
                    n_seq = {i_dibit, r_seq[15:2]};
                end else begin
                    n_len = {i_dibit, r_len[15:2]};
                end
                n_pos = pos_inc;
                if (r_pos[4:0] == HDR_LAST_POS) begin
                    n_seq     = swap16(r_seq);
                    n_len     = len_swapped;
                    n_pos     = '0;
                    n_cnt     = '0;
                    res_valid = 1'b1;
                    if (len_swapped > i_cfg.max_len) begin
                        n_mode   = M_SEARCH;
                        res_kind = KIND_OVERSIZE;
                    end else if (len_swapped == 16'h0000) begin
                        n_mode   = M_SEARCH;
                        res_kind = KIND_KEEPALIVE;
                    end else begin
                        n_mode   = M_PAYLOAD;
                        n_lfsr   = LFSR_SEED;
                        n_gather = '0;
                        res_kind = KIND_HEADER;
                    end
                end
            end
            M_PAYLOAD: begin
                // two descrambled bits per dibit
                n_lfsr   = lfsr_b;
                n_pos    = pos_inc;
                n_gather = r_gather | ({6'b0, b1, b0} << r_pos[2:0]);
                if (r_pos[2:0] == BYTE_LAST_SH) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_PAYLOAD;
                    res_byte  = {b1, b0, r_gather[5:0]};
                    res_last  = (pos_inc >= {r_len, 3'b000});
                    n_gather  = '0;
                    if (res_last) begin
                        n_mode = M_SEARCH;
                        n_pos  = '0;
                        n_cnt  = '0;
                    end
                end
            end
            default: begin
                // sync run search, count saturates
                n_mode = M_SEARCH;
                if (i_dibit == i_cfg.sync_symbol) begin
                    n_cnt = cnt_sat;
                    if (cnt_sat >= i_cfg.sync_run) begin
                        n_mode = M_HEADER;
                        n_pos  = '0;
                        n_cnt  = '0;
                    end
                end else begin
                    n_cnt = '0;
                end
            end
        endcase
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_SEARCH;
            r_pos    <= '0;
            r_cnt    <= '0;
            r_seq    <= '0;
            r_len    <= '0;
            r_lfsr   <= LFSR_SEED;
            r_gather <= '0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_cnt    <= n_cnt;
            r_seq    <= n_seq;
            r_len    <= n_len;
            r_lfsr   <= n_lfsr;
            r_gather <= n_gather;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_step && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_step && res_valid) begin
            r_kind    <= res_kind;
            r_byte    <= res_byte;
            r_out_seq <= n_seq;
            r_out_len <= n_len;
            r_last    <= res_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_event_kind      = r_kind;
    assign o_payload_byte    = r_byte;
    assign o_sequence_number = r_out_seq;
    assign o_frame_length    = r_out_len;
    assign o_last_byte       = r_last;

endmodule

>>> design/dibit_frame_deframer_descrambler.sv
// top level of the dibit frame deframer with payload descrambler
// Takes one dibit per cycle, unless a result is stalled, and gives at most
// one result per dibit: a descrambled payload byte, a header event (accepted,
// keep-alive or oversize). Sustained rate is one dibit per clock while the
// downstream side takes each result; each dibit goes from the input register
// through the parse logic into the result register. The only thing that
// holds the input back is a result that the downstream side has not taken.
// Configuration writes are taken in every cycle and act from the next dibit.
module dibit_frame_deframer_descrambler
    import dfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_dibit,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_event_kind,
    output logic [7:0]            o_payload_byte,
    output logic [15:0]           o_sequence_number,
    output logic [15:0]           o_frame_length,
    output logic                  o_last_byte
);

    t_cfg       cfg;
    logic       r_in_valid;
    logic [1:0] r_in_dibit;
    logic       step;

    dfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // a buffered dibit moves on when the result slot is free or draining
    assign step    = r_in_valid && (!o_valid || i_ready);
    assign o_ready = !r_in_valid || step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_dibit <= i_dibit;
        end
    end

    dfd_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_step            (step),
        .i_dibit           (r_in_dibit),
        .i_out_ready       (i_ready),
        .o_out_valid       (o_valid),
        .o_event_kind      (o_event_kind),
        .o_payload_byte    (o_payload_byte),
        .o_sequence_number (o_sequence_number),
        .o_frame_length    (o_frame_length),
        .o_last_byte       (o_last_byte)
    );

endmodule

>>> design/dfd_checker.sv
// port-level checks of the dibit frame deframer, bound to the top level
module dfd_port_checks
    import dfd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_event_kind,
    input logic [7:0]  o_payload_byte,
    input logic [15:0] o_frame_length,
    input logic        o_last_byte
);

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_event_kind)
            && $stable(o_payload_byte) && $stable(o_last_byte))
        else $error("stalled result changed");

    // header events carry no byte and no last mark
    a_event_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_kind != KIND_PAYLOAD |-> !o_last_byte && o_payload_byte == 8'h00)
        else $error("header event with payload fields set");

    // keep-alive means zero length
    a_keepalive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_kind == KIND_KEEPALIVE |-> o_frame_length == 16'h0000)
        else $error("keep-alive with nonzero length");

    // accepted header means nonzero length
    a_header_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_kind == KIND_HEADER |-> o_frame_length != 16'h0000)
        else $error("header accepted with zero length");

endmodule

bind dibit_frame_deframer_descrambler dfd_port_checks u_dfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_event_kind   (o_event_kind),
    .o_payload_byte (o_payload_byte),
    .o_frame_length (o_frame_length),
    .o_last_byte    (o_last_byte)
);
